// File: sv/bbec_pkg.sv
// Package for the bit/block error counter table.
// Item types, counter width and code constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbec_pkg;

    localparam int COUNTER_WIDTH  = 32;
    localparam int USER_COUNT_DEF = 16;
    localparam int SLOT_COUNT_DEF = 256;
    localparam int BYTE_BITS      = 8;

    // compare_mode codes
    localparam logic [1:0] CMP_NONE    = 2'd0;
    localparam logic [1:0] CMP_CODED   = 2'd1;
    localparam logic [1:0] CMP_UNCODED = 2'd2;

    // bits_target codes
    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_CODED   = 2'd1;
    localparam logic [1:0] TGT_UNCODED = 2'd2;

    typedef struct packed {
        logic [3:0]  user;
        logic [7:0]  slot;
        logic [7:0]  sent_byte;
        logic [7:0]  received_byte;
        logic [1:0]  compare_mode;
        logic [3:0]  modulation_bits;
        logic [15:0] new_bits;
        logic [1:0]  bits_target;
        logic        block_done;
        logic [15:0] block_errors;
    } in_item_t;

    // Also the layout of one table entry in memory.
    typedef struct packed {
        logic [COUNTER_WIDTH-1:0] coded_bit_errors;
        logic [COUNTER_WIDTH-1:0] coded_bits;
        logic [COUNTER_WIDTH-1:0] blocks_in_error;
        logic [COUNTER_WIDTH-1:0] blocks_decoded;
        logic [COUNTER_WIDTH-1:0] uncoded_bit_errors;
        logic [COUNTER_WIDTH-1:0] uncoded_bits;
    } result_t;

endpackage

`default_nettype wire

// File: sv/bbec_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/bbec_update.sv
// Counter update: bit error count and six saturating adds for one entry.
// Depends on bbec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbec_update
    import bbec_pkg::*;
(
    input  wire in_item_t item,
    input  wire result_t  cur,
    output result_t       nxt
);

    function automatic logic [COUNTER_WIDTH-1:0] sat_add(
        input logic [COUNTER_WIDTH-1:0] a,
        input logic [COUNTER_WIDTH-1:0] b
    );
        logic [COUNTER_WIDTH:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[COUNTER_WIDTH] ? '1 : s[COUNTER_WIDTH-1:0];
        end
    endfunction

    logic [7:0] diff;
    logic [8:0] low_mask;
    logic [7:0] unc_mask;
    logic [3:0] coded_errs;
    logic [3:0] unc_errs;
    logic [COUNTER_WIDTH-1:0] add_bits;

    assign diff     = item.sent_byte ^ item.received_byte;
    assign low_mask = (9'd1 << item.modulation_bits) - 9'd1;
    // more than a byte's worth of modulation bits compares the whole byte
    assign unc_mask = (item.modulation_bits > 4'(BYTE_BITS)) ? 8'hFF : low_mask[7:0];
    assign add_bits = COUNTER_WIDTH'(item.new_bits);

    always_comb
    begin
        coded_errs = '0;
        unc_errs   = '0;
        for (int i = 0; i < BYTE_BITS; i++)
        begin
            coded_errs = coded_errs + 4'(diff[i]);
            unc_errs   = unc_errs + 4'(diff[i] & unc_mask[i]);
        end
    end

    always_comb
    begin
        nxt = cur;
        if (item.compare_mode == CMP_CODED)
        begin
            nxt.coded_bit_errors = sat_add(cur.coded_bit_errors,
                                           COUNTER_WIDTH'(coded_errs));
        end
        else if (item.compare_mode == CMP_UNCODED)
        begin
            nxt.uncoded_bit_errors = sat_add(cur.uncoded_bit_errors,
                                             COUNTER_WIDTH'(unc_errs));
        end

        if (item.bits_target == TGT_CODED)
        begin
            nxt.coded_bits = sat_add(cur.coded_bits, add_bits);
        end
        else if (item.bits_target == TGT_UNCODED)
        begin
            nxt.uncoded_bits = sat_add(cur.uncoded_bits, add_bits);
        end

        if (item.block_done)
        begin
            nxt.blocks_decoded = sat_add(cur.blocks_decoded, COUNTER_WIDTH'(1));
        end
        if (item.block_errors != 16'd0)
        begin
            nxt.blocks_in_error = sat_add(cur.blocks_in_error, COUNTER_WIDTH'(1));
        end
    end

endmodule

`default_nettype wire

// File: sv/bit_block_error_counter_table.sv
// Top level of the bit/block error counter table.
// Depends on bbec_pkg, bbec_ram and bbec_update.
`timescale 1ns / 1ps
`default_nettype none

// Keeps six saturating link-quality counters per (user, slot) entry in one
// wide synchronous RAM and returns the entry's updated counters for every
// item. An item is taken when start is high and busy is low. In the accept
// cycle the entry is read, in the following cycle the counters are updated
// and written back, and the result appears on result with done high for
// exactly one cycle after that; busy drops in that same cycle, so the next
// item may be taken while the result is shown. The one RAM read/write port
// pair keeps the block to one item at a time; since busy covers the
// write-back, two items never touch the memory at the same time. The receiver
// cannot stall: sample result whenever done is high. After reset the block
// clears the table, one entry per cycle, all USER_COUNT * SLOT_COUNT entries
// (4096 by default) with busy high. An item with user or slot out of range
// changes nothing and returns all-zero counters. Counters are COUNTER_WIDTH
// bits (package constant) and stick at all ones.

module bit_block_error_counter_table
    import bbec_pkg::*;
#(
    parameter int USER_COUNT = USER_COUNT_DEF,
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t item,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    localparam int ENTRY_COUNT = USER_COUNT * SLOT_COUNT;
    localparam int AW          = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int MW          = AW + 13;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] clr_idx_reg;
    in_item_t      item_reg;
    logic [AW-1:0] idx_reg;
    logic          in_range_reg;
    logic          done_reg;
    result_t       result_reg;

    logic          accept;
    logic [MW-1:0] idx_full;
    logic [AW-1:0] idx_in;
    logic          in_range_in;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    result_t       ram_wdata;
    result_t       ram_rdata;
    result_t       upd_next;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // entry index = user * SLOT_COUNT + slot
    assign idx_full    = MW'(item.user) * MW'(SLOT_COUNT) + MW'(item.slot);
    assign idx_in      = idx_full[AW-1:0];
    assign in_range_in = (32'(item.user) < USER_COUNT) && (32'(item.slot) < SLOT_COUNT);

    bbec_ram #(
        .WIDTH ($bits(result_t)),
        .DEPTH (ENTRY_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_in),
        .rdata (ram_rdata)
    );

    bbec_update u_update (
        .item (item_reg),
        .cur  (ram_rdata),
        .nxt  (upd_next)
    );

    // write port: clearing sweep, then write-back of updated entries
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = upd_next;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            S_UPDATE:
            begin
                ram_we = in_range_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            item_reg     <= '0;
            idx_reg      <= '0;
            in_range_reg <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                    if (clr_idx_reg == AW'(ENTRY_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg     <= item;
                        idx_reg      <= idx_in;
                        in_range_reg <= in_range_in;
                        state_reg    <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    result_reg <= in_range_reg ? upd_next : '0;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a result only follows an update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPDATE))
        else $error("result strobe without a preceding update");

    // an accepted item is updated in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_UPDATE))
        else $error("accepted item not updated");

    // nothing is written to the table while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("table write while idle");

    // an out-of-range entry returns zero counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range_reg) |-> (result == '0))
        else $error("out-of-range item returned nonzero counters");

    // no item is taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !accept)
        else $error("item accepted during table clear");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for bit_block_error_counter_table.
// Needs bbec_pkg and the block's RTL; keeps its own copy of the counter table.
`timescale 1ns / 1ps

module tb_top;
    import bbec_pkg::*;

    localparam int USERS       = USER_COUNT_DEF;
    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int ENTRIES     = USERS * SLOTS;
    localparam int CW          = COUNTER_WIDTH;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_CAP  = 100;   // $error lines before going quiet
    localparam int RANDOM_ITEMS = 1180;

    // Codes the package leaves unnamed; the block treats both as "do nothing".
    localparam logic [1:0] CMP_SPARE = 2'd3;
    localparam logic [1:0] TGT_SPARE = 2'd3;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    in_item_t item  = '0;
    logic     busy;
    logic     done;
    result_t  result;

    // Local copy of every entry's six counters, updated as items are taken.
    result_t entry_table [ENTRIES];
    result_t counts_due [$];

    int unsigned cycle_count  = 0;
    int unsigned fail_count   = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned idle_pct     = 15;

    logic [3:0] hot_user [4];
    logic [7:0] hot_slot [4];

    bit_block_error_counter_table #(
        .USER_COUNT(USERS),
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .done  (done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [CW-1:0] sat_sum(logic [CW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    function automatic int unsigned ones_in(logic [7:0] v, int unsigned nbits);
        int unsigned n;
        n = 0;
        for (int i = 0; i < nbits && i < BYTE_BITS; i++)
            n += v[i];
        return n;
    endfunction

    // Applies one event to the local table and returns the entry afterwards.
    function automatic result_t tally_event(in_item_t ev);
        int unsigned idx;
        int unsigned mbits;
        logic [7:0]  diff;
        result_t     cnt;
        if (ev.user >= USERS || ev.slot >= SLOTS)
            return '0;
        idx   = ev.user * SLOTS + ev.slot;
        cnt   = entry_table[idx];
        diff  = ev.sent_byte ^ ev.received_byte;
        mbits = (ev.modulation_bits > BYTE_BITS) ? BYTE_BITS : ev.modulation_bits;
        case (ev.compare_mode)
            CMP_CODED:
                cnt.coded_bit_errors = sat_sum(cnt.coded_bit_errors, ones_in(diff, BYTE_BITS));
            CMP_UNCODED:
                cnt.uncoded_bit_errors = sat_sum(cnt.uncoded_bit_errors, ones_in(diff, mbits));
            default: ;
        endcase
        case (ev.bits_target)
            TGT_CODED:   cnt.coded_bits   = sat_sum(cnt.coded_bits, CW'(ev.new_bits));
            TGT_UNCODED: cnt.uncoded_bits = sat_sum(cnt.uncoded_bits, CW'(ev.new_bits));
            default: ;
        endcase
        if (ev.block_done)
            cnt.blocks_decoded = sat_sum(cnt.blocks_decoded, CW'(1));
        if (ev.block_errors != 16'd0)
            cnt.blocks_in_error = sat_sum(cnt.blocks_in_error, CW'(1));
        entry_table[idx] = cnt;
        return cnt;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(string field, logic [CW-1:0] want, logic [CW-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (counts_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("result item with nothing expected");
            end
            else
            begin
                want = counts_due.pop_front();
                results_seen++;
                check_field("coded_bit_errors", want.coded_bit_errors, result.coded_bit_errors);
                check_field("coded_bits", want.coded_bits, result.coded_bits);
                check_field("blocks_in_error", want.blocks_in_error, result.blocks_in_error);
                check_field("blocks_decoded", want.blocks_decoded, result.blocks_decoded);
                check_field("uncoded_bit_errors", want.uncoded_bit_errors,
                            result.uncoded_bit_errors);
                check_field("uncoded_bits", want.uncoded_bits, result.uncoded_bits);
            end
        end
    end

    // ---------------------------------------------------------------- driving

    // Entered and left just after a falling edge. start is left high on return
    // so that back-to-back items never lower and raise it in one time step.
    task automatic send_event(in_item_t ev);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= ev;
        do
            @(posedge clk);
        while (busy);
        counts_due.push_back(tally_event(ev));
        items_sent++;
        @(negedge clk);
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (counts_due.size() != 0);
    endtask

    function automatic in_item_t make_event(
        logic [3:0] user, logic [7:0] slot, logic [7:0] sent, logic [7:0] recv,
        logic [1:0] mode, logic [3:0] mbits, logic [15:0] nbits, logic [1:0] tgt,
        logic blk_done, logic [15:0] blk_err);
        in_item_t ev;
        ev.user            = user;
        ev.slot            = slot;
        ev.sent_byte       = sent;
        ev.received_byte   = recv;
        ev.compare_mode    = mode;
        ev.modulation_bits = mbits;
        ev.new_bits        = nbits;
        ev.bits_target     = tgt;
        ev.block_done      = blk_done;
        ev.block_errors    = blk_err;
        return ev;
    endfunction

    // ---------------------------------------------------------------- tests

    // Fresh entries read back as zero; no-op items at the corners and middle of the table.
    task automatic test_cleared_table();
        send_event(make_event(4'd0, 8'd0, 8'h00, 8'hFF, CMP_NONE, 4'd8, 16'hFFFF, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd15, 8'd255, 8'hFF, 8'h00, CMP_NONE, 4'd15, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd7, 8'd128, 8'h5A, 8'hA5, CMP_SPARE, 4'd0, 16'h8000, TGT_SPARE,
                              1'b0, 16'd0));
    endtask

    task automatic test_coded_compare();
        send_event(make_event(4'd1, 8'd1, 8'h00, 8'hFF, CMP_CODED, 4'd0, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd1, 8'd1, 8'hA5, 8'hA5, CMP_CODED, 4'd2, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        // spare mode and "none" must leave both error counts alone
        send_event(make_event(4'd1, 8'd1, 8'h00, 8'hFF, CMP_SPARE, 4'd8, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd1, 8'd1, 8'h00, 8'hFF, CMP_NONE, 4'd8, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
    endtask

    // Uncoded compare: zero bits, one bit, full byte, and widths above a byte.
    task automatic test_uncoded_compare();
        send_event(make_event(4'd2, 8'd3, 8'h00, 8'hFF, CMP_UNCODED, 4'd0, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd2, 8'd3, 8'h00, 8'hFF, CMP_UNCODED, 4'd1, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd2, 8'd3, 8'h00, 8'hFF, CMP_UNCODED, 4'd8, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd2, 8'd3, 8'h00, 8'hFF, CMP_UNCODED, 4'd9, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        send_event(make_event(4'd2, 8'd3, 8'hFF, 8'h00, CMP_UNCODED, 4'd15, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
        // only bit 7 differs and seven bits are compared: no error
        send_event(make_event(4'd2, 8'd3, 8'hFF, 8'h7F, CMP_UNCODED, 4'd7, 16'd0, TGT_NONE,
                              1'b0, 16'd0));
    endtask

    task automatic test_bit_totals();
        send_event(make_event(4'd3, 8'd4, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'd0, TGT_CODED,
                              1'b0, 16'd0));
        send_event(make_event(4'd3, 8'd4, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'hFFFF, TGT_CODED,
                              1'b0, 16'd0));
        send_event(make_event(4'd3, 8'd4, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'hFFFF, TGT_UNCODED,
                              1'b0, 16'd0));
        send_event(make_event(4'd3, 8'd4, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'hFFFF, TGT_SPARE,
                              1'b0, 16'd0));
        send_event(make_event(4'd3, 8'd4, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'd1234, TGT_NONE,
                              1'b0, 16'd0));
    endtask

    // Any nonzero block_errors counts exactly one block error.
    task automatic test_block_counts();
        send_event(make_event(4'd4, 8'd5, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'd0, TGT_NONE,
                              1'b1, 16'd0));
        send_event(make_event(4'd4, 8'd5, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'd0, TGT_NONE,
                              1'b0, 16'd1));
        send_event(make_event(4'd4, 8'd5, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'd0, TGT_NONE,
                              1'b1, 16'hFFFF));
        send_event(make_event(4'd4, 8'd5, 8'h00, 8'h00, CMP_NONE, 4'd0, 16'd0, TGT_NONE,
                              1'b0, 16'h8000));
    endtask

    // All four updates in one item, back to back on the same entry.
    task automatic test_combined_updates();
        send_event(make_event(4'd15, 8'd255, 8'hFF, 8'h00, CMP_UNCODED, 4'd4, 16'hFFFF,
                              TGT_UNCODED, 1'b1, 16'd1));
        send_event(make_event(4'd15, 8'd255, 8'hF0, 8'h0F, CMP_CODED, 4'd4, 16'hFFFF,
                              TGT_CODED, 1'b1, 16'hFFFF));
    endtask

    // Bit totals need about 64k items at the largest step to reach all ones,
    // far past the item budget; this runs largest steps back to back on one
    // entry so both totals carry well past 16 bits. No idling: clean stretch.
    task automatic test_large_totals();
        in_item_t ev;
        idle_pct = 0;
        for (int n = 0; n < 100; n++)
        begin
            ev = make_event(4'd9, 8'd90, 8'($urandom), 8'($urandom), 2'($urandom_range(3)),
                            4'($urandom_range(15)), 16'hFFFF, n[0] ? TGT_CODED : TGT_UNCODED,
                            1'($urandom_range(1)), ($urandom_range(1) != 0) ? 16'd0 : 16'd7);
            send_event(ev);
        end
        idle_pct = 15;
    endtask

    function automatic in_item_t random_event();
        in_item_t ev;
        int unsigned pick;
        ev = '0;
        ev.sent_byte     = 8'($urandom);
        ev.received_byte = ($urandom_range(4) == 0) ? ev.sent_byte : 8'($urandom);
        // three in four items hit a few hot entries so state builds up
        if ($urandom_range(3) != 0)
        begin
            pick    = $urandom_range(3);
            ev.user = hot_user[pick];
            ev.slot = hot_slot[pick];
        end
        else
        begin
            ev.user = 4'($urandom);
            ev.slot = 8'($urandom);
        end
        ev.compare_mode    = 2'($urandom_range(3));
        ev.modulation_bits = ($urandom_range(9) < 7) ? 4'($urandom_range(8)) : 4'($urandom);
        case ($urandom_range(9))
            0:       ev.new_bits = 16'hFFFF;
            1:       ev.new_bits = 16'd0;
            default: ev.new_bits = 16'($urandom);
        endcase
        ev.bits_target  = 2'($urandom_range(3));
        ev.block_done   = 1'($urandom_range(1));
        ev.block_errors = ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom);
        return ev;
    endfunction

    task automatic test_random_traffic();
        for (int i = 0; i < 4; i++)
        begin
            hot_user[i] = 4'($urandom);
            hot_slot[i] = 8'($urandom);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_pct = (i >= 300 && i < 500) ? 0 : 15;
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            send_event(random_event());
        end
        idle_pct = 15;
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        foreach (entry_table[i])
            entry_table[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // send_event waits out the clearing pass through busy
        test_cleared_table();
        test_coded_compare();
        test_uncoded_compare();
        test_bit_totals();
        test_block_counts();
        test_combined_updates();
        drain_results();
        test_large_totals();
        test_random_traffic();

        start <= 1'b0;
        while (counts_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run covered %0d items and %0d result items over %0d cycles:",
                 items_sent, results_seen, cycle_count);
        $display("  field extremes, all modes and targets, large bit totals, random traffic");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
